/* design/rusnh_pkg.sv */
// ---------------------------------------------------------------------------
// rusnh_pkg
// Shared types, constants and tables of the ray / unit square nearest hit
// block.
// ---------------------------------------------------------------------------
`default_nettype none

package rusnh_pkg;

   localparam int ANGLE_BITS_DEFAULT = 16;
   localparam int FRAC_BITS_DEFAULT  = 16;
   localparam int CORDIC_STEPS       = 24;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

   // register indexes of the control port
   localparam logic [1:0] CSR_ORIGIN_X  = 2'd0;
   localparam logic [1:0] CSR_ORIGIN_Y  = 2'd1;
   localparam logic [1:0] CSR_RAY_ANGLE = 2'd2;

   typedef struct packed {
      logic signed [31:0] block_x;
      logic signed [31:0] block_y;
      logic               last_block;
   } req_type;

   typedef struct packed {
      logic [31:0] distance;
      logic        hit;
   } rsp_type;

   // square as queued between front and back
   typedef struct packed {
      req_type blk;
      logic    skip;
   } item_type;

   // arctangent of 2^-i in turns, signed Q1.32, full circle = 2^32
   function automatic logic signed [32:0] atan_step(input logic [4:0] i);
      logic signed [32:0] v;
      begin
         unique case (i)
            5'd0:  v = 33'sd536870912;
            5'd1:  v = 33'sd316933406;
            5'd2:  v = 33'sd167458907;
            5'd3:  v = 33'sd85004756;
            5'd4:  v = 33'sd42667331;
            5'd5:  v = 33'sd21354465;
            5'd6:  v = 33'sd10679838;
            5'd7:  v = 33'sd5340245;
            5'd8:  v = 33'sd2670163;
            5'd9:  v = 33'sd1335087;
            5'd10: v = 33'sd667544;
            5'd11: v = 33'sd333772;
            5'd12: v = 33'sd166886;
            5'd13: v = 33'sd83443;
            5'd14: v = 33'sd41722;
            5'd15: v = 33'sd20861;
            5'd16: v = 33'sd10430;
            5'd17: v = 33'sd5215;
            5'd18: v = 33'sd2608;
            5'd19: v = 33'sd1304;
            5'd20: v = 33'sd652;
            5'd21: v = 33'sd326;
            5'd22: v = 33'sd163;
            5'd23: v = 33'sd81;
            default: v = 33'sd0;
         endcase
         return v;
      end
   endfunction

endpackage

`default_nettype wire

/* design/rusnh_dir.sv */
// ---------------------------------------------------------------------------
// rusnh_dir
// Holds the ray angle and turns it into a unit direction with an iterative
// CORDIC, one rotation step per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module rusnh_dir
   import rusnh_pkg::*;
#(
   parameter int ANGLE_BITS = ANGLE_BITS_DEFAULT,
   parameter int FRAC_BITS  = FRAC_BITS_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        angle_we,
   input  wire logic [15:0]                 angle_data,
   output logic                             busy,
   output logic signed [FRAC_BITS+1:0]      nx,
   output logic signed [FRAC_BITS+1:0]      ny
);

   localparam int AW = (ANGLE_BITS < 16) ? ANGLE_BITS : 16;
   localparam int DW = FRAC_BITS + 2;

   logic [AW-1:0]        angle_ff;
   logic                 start_ff, busy_ff;
   logic [4:0]           step_ff;
   logic [1:0]           quad_ff;
   logic signed [33:0]   x_ff, y_ff;
   logic signed [32:0]   z_ff;
   logic signed [DW-1:0] nx_ff, ny_ff;

   logic [15:0]          a16;
   logic [31:0]          u;
   logic signed [33:0]   dx, dy, rnd, xr, yr;
   logic signed [DW-1:0] c, s;

   always_comb begin
      a16 = 16'(angle_ff) << (16 - AW);
      u   = {a16, 16'h0000} + 32'h2000_0000;
      dx  = y_ff >>> step_ff;
      dy  = x_ff >>> step_ff;
      rnd = 34'sd1 <<< (29 - FRAC_BITS);
      xr  = (x_ff + rnd) >>> (30 - FRAC_BITS);
      yr  = (y_ff + rnd) >>> (30 - FRAC_BITS);
      c   = DW'(xr);
      s   = DW'(yr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff <= '0;
         start_ff <= 1'b1;
         busy_ff  <= 1'b1;
         step_ff  <= '0;
      end else if (angle_we) begin
         angle_ff <= angle_data[15 -: AW];
         start_ff <= 1'b1;
         busy_ff  <= 1'b1;
      end else if (start_ff) begin
         start_ff <= 1'b0;
         step_ff  <= '0;
      end else if (busy_ff) begin
         if (step_ff == 5'(CORDIC_STEPS)) begin
            busy_ff <= 1'b0;
         end else begin
            step_ff <= step_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start_ff) begin
         x_ff    <= CORDIC_GAIN;
         y_ff    <= '0;
         z_ff    <= $signed({3'b000, u[29:0]}) - 33'sd536870912;
         quad_ff <= u[31:30];
      end else if (busy_ff && step_ff != 5'(CORDIC_STEPS)) begin
         if (!z_ff[32]) begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - atan_step(step_ff);
         end else begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + atan_step(step_ff);
         end
      end else if (busy_ff) begin
         // fold the quadrant back in
         unique case (quad_ff)
            2'd0: begin nx_ff <= c;  ny_ff <= s;  end
            2'd1: begin nx_ff <= -s; ny_ff <= c;  end
            2'd2: begin nx_ff <= -c; ny_ff <= -s; end
            2'd3: begin nx_ff <= s;  ny_ff <= -c; end
         endcase
      end
   end

   assign busy = busy_ff | start_ff;
   assign nx   = nx_ff;
   assign ny   = ny_ff;

endmodule

`default_nettype wire

/* design/rusnh_front.sv */
// ---------------------------------------------------------------------------
// rusnh_front
// Accepts squares, flags those that contain the ray origin, and queues them
// in a two entry buffer for the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module rusnh_front
   import rusnh_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   input  wire req_type            req_data,
   output logic                    req_full,
   input  wire logic               hold,
   input  wire logic signed [31:0] origin_x,
   input  wire logic signed [31:0] origin_y,
   output logic                    item_valid,
   input  wire logic               item_take,
   output item_type                item
);

   item_type           buf_ff [2];
   logic               wr_ptr_ff, rd_ptr_ff;
   logic [1:0]         count_ff;
   logic               accept;
   logic signed [33:0] half, ox, oy, bx, by;
   logic               holds_origin;

   always_comb begin
      half   = 34'sd1 <<< (FRAC_BITS - 1);
      ox     = 34'(origin_x);
      oy     = 34'(origin_y);
      bx     = 34'(req_data.block_x);
      by     = 34'(req_data.block_y);
      holds_origin = (ox <= bx + half) && (ox >= bx - half) &&
                     (oy >= by - half) && (oy <= by + half);
   end

   assign req_full   = (count_ff == 2'd2) | hold;
   assign accept     = req_push & ~req_full;
   assign item_valid = (count_ff != 2'd0);
   assign item       = buf_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (accept) begin
         buf_ff[wr_ptr_ff] <= '{blk: req_data, skip: holds_origin};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (accept) wr_ptr_ff <= ~wr_ptr_ff;
         if (item_take) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + 2'(accept) - 2'(item_take);
      end
   end

endmodule

`default_nettype wire

/* design/rusnh_back.sv */
// ---------------------------------------------------------------------------
// rusnh_back
// Tests one square edge at a time: bit serial division for the ray
// parameter, one multiply for the crossing, then the running minimum.
// ---------------------------------------------------------------------------
`default_nettype none

module rusnh_back
   import rusnh_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic signed [31:0]          origin_x,
   input  wire logic signed [31:0]          origin_y,
   input  wire logic signed [FRAC_BITS+1:0] nx,
   input  wire logic signed [FRAC_BITS+1:0] ny,
   input  wire logic                        item_valid,
   input  wire item_type                    item,
   output logic                             item_take,
   output logic                             rsp_empty,
   input  wire logic                        rsp_pop,
   output rsp_type                          rsp_data
);

   localparam int NW = 34;
   localparam int GW = FRAC_BITS + 2;
   localparam int RW = FRAC_BITS + 3;
   localparam int PW = FRAC_BITS + 35;
   localparam int TW = 38;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_SETUP = 6'b000010,
      S_DIV   = 6'b000100,
      S_MUL   = 6'b001000,
      S_CHECK = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type            state_ff;
   logic [1:0]           edge_ff;
   logic [31:0]          best_ff;
   logic                 any_ff;
   logic [RW-1:0]        rem_ff;
   logic [31:0]          quo_ff, t_ff;
   logic [4:0]           cnt_ff;
   logic [GW-1:0]        den_ff;
   logic signed [PW-1:0] prod_ff;
   logic                 out_valid_ff;
   rsp_type              out_ff;

   logic                 use_y, sx_neg, sy_neg, side_neg, last_edge;
   logic signed [NW-1:0] half, ox, oy, bx, by, sxh, syh, num, num_mag;
   logic signed [GW-1:0] den, other;
   logic [GW-1:0]        den_mag;
   logic                 positive, sat;
   logic [NW+FRAC_BITS-1:0] dividend;
   logic [RW-1:0]        shifted, den_ext;
   logic                 ge;
   logic [31:0]          quo_in;
   logic signed [TW-1:0] p, base, tp, one;
   logic                 on_edge, out_free;

   // edge 0: bottom, 1: right, 2: top, 3: left
   always_comb begin
      use_y    = ~edge_ff[0];
      sx_neg   = (edge_ff == 2'd0) || (edge_ff == 2'd3);
      sy_neg   = (edge_ff == 2'd0) || (edge_ff == 2'd1);
      side_neg = edge_ff[1];
      last_edge = (edge_ff == 2'd3);

      half = 34'sd1 <<< (FRAC_BITS - 1);
      ox   = NW'(origin_x);
      oy   = NW'(origin_y);
      bx   = NW'(item.blk.block_x);
      by   = NW'(item.blk.block_y);
      sxh  = sx_neg ? -half : half;
      syh  = sy_neg ? -half : half;
      num  = use_y ? (by + syh - oy) : (bx + sxh - ox);
      den  = use_y ? ny : nx;
      other = use_y ? nx : ny;
      num_mag = num[NW-1] ? -num : num;
      den_mag = den[GW-1] ? GW'(-den) : GW'(den);
      positive = (num != '0) && (den != '0) && (num[NW-1] == den[GW-1]);
      dividend = {num_mag, {FRAC_BITS{1'b0}}};
      // quotient would not fit in 32 bits
      sat = dividend >= {den_mag, 32'h0};

      shifted = {rem_ff[RW-2:0], quo_ff[31]};
      den_ext = RW'(den_ff);
      ge      = shifted >= den_ext;
      quo_in  = {quo_ff[30:0], ge};

      one  = 38'sd1 <<< FRAC_BITS;
      p    = TW'(prod_ff >>> FRAC_BITS);
      // crossing lies along the axis other than the one divided by
      base = use_y ? (TW'(ox) + p - TW'(bx) - TW'(sxh))
                   : (TW'(oy) + p - TW'(by) - TW'(syh));
      tp   = side_neg ? -base : base;
      on_edge = !tp[TW-1] && (tp <= one);

      out_free  = ~out_valid_ff | rsp_pop;
      item_take = (state_ff == S_DONE) && (!item.blk.last_block || out_free);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         edge_ff      <= '0;
         best_ff      <= '1;
         any_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (item_take && item.blk.last_block) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop && out_valid_ff) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               edge_ff <= '0;
               if (item_valid) state_ff <= item.skip ? S_DONE : S_SETUP;
            end
            S_SETUP: begin
               if (!positive) begin
                  edge_ff  <= edge_ff + 2'd1;
                  state_ff <= last_edge ? S_DONE : S_SETUP;
               end else if (sat) begin
                  state_ff <= S_MUL;
               end else begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (cnt_ff == 5'd31) state_ff <= S_MUL;
            end
            S_MUL: begin
               if (t_ff == '0) begin
                  edge_ff  <= edge_ff + 2'd1;
                  state_ff <= last_edge ? S_DONE : S_SETUP;
               end else begin
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               if (on_edge) begin
                  any_ff <= 1'b1;
                  if (t_ff < best_ff) best_ff <= t_ff;
               end
               edge_ff  <= edge_ff + 2'd1;
               state_ff <= last_edge ? S_DONE : S_SETUP;
            end
            S_DONE: begin
               if (item_take) begin
                  state_ff <= S_IDLE;
                  if (item.blk.last_block) begin
                     best_ff <= '1;
                     any_ff  <= 1'b0;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // datapath, no reset
   always_ff @(posedge clock) begin
      if (state_ff == S_SETUP) begin
         rem_ff <= RW'(dividend[NW+FRAC_BITS-1:32]);
         quo_ff <= dividend[31:0];
         den_ff <= den_mag;
         cnt_ff <= '0;
         t_ff   <= '1;
      end
      if (state_ff == S_DIV) begin
         rem_ff <= ge ? (shifted - den_ext) : shifted;
         quo_ff <= quo_in;
         cnt_ff <= cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) t_ff <= quo_in;
      end
      if (state_ff == S_MUL) begin
         prod_ff <= $signed({1'b0, t_ff}) * other;
      end
      if (item_take && item.blk.last_block) begin
         out_ff.distance <= best_ff;
         out_ff.hit      <= any_ff;
      end
   end

   assign rsp_empty = ~out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire

/* design/ray_unit_square_nearest_hit_top.sv */
// ---------------------------------------------------------------------------
// ray_unit_square_nearest_hit_top
// Nearest hit of a 2D ray against a stream of unit squares.
// ---------------------------------------------------------------------------
// In the back end a square that holds the ray origin passes only the idle and done
// states; otherwise it passes idle, then for each square edge in turn a setup state
// plus, when the ray can cross it, a bit serial divide (skipped when the parameter
// saturates), a multiply and a check (not for a zero parameter), then done. Squares
// go one at a time. The result is registered and appears in the cycle after the last
// square finishes. Reset clears the control registers and the set state; the
// direction CORDIC then runs (also after each angle write), input held full meanwhile.
`default_nettype none

module ray_unit_square_nearest_hit_top
   import rusnh_pkg::*;
#(
   parameter int ANGLE_BITS = ANGLE_BITS_DEFAULT,
   parameter int FRAC_BITS  = FRAC_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire req_type     req_data,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output rsp_type          rsp_data,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   logic signed [31:0]          origin_x_ff, origin_y_ff;
   logic                        dir_busy, angle_we;
   logic signed [FRAC_BITS+1:0] nx, ny;
   logic                        item_valid, item_take;
   item_type                    item;

   assign angle_we = csr_we && (csr_index == CSR_RAY_ANGLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
      end else if (csr_we) begin
         if (csr_index == CSR_ORIGIN_X) origin_x_ff <= csr_data;
         if (csr_index == CSR_ORIGIN_Y) origin_y_ff <= csr_data;
      end
   end

   rusnh_dir #(
      .ANGLE_BITS (ANGLE_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dir (
      .clock      (clock),
      .reset      (reset),
      .angle_we   (angle_we),
      .angle_data (csr_data[15:0]),
      .busy       (dir_busy),
      .nx         (nx),
      .ny         (ny)
   );

   rusnh_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_data   (req_data),
      .req_full   (req_full),
      .hold       (dir_busy),
      .origin_x   (origin_x_ff),
      .origin_y   (origin_y_ff),
      .item_valid (item_valid),
      .item_take  (item_take),
      .item       (item)
   );

   rusnh_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .origin_x   (origin_x_ff),
      .origin_y   (origin_y_ff),
      .nx         (nx),
      .ny         (ny),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire
